// ===== src/dlte_pkg.sv =====
// package: shared types, codes and constants of the dense layer engine
`timescale 1ns / 1ps
`default_nettype none
package dlte_pkg;

  localparam int DEF_MAX_INPUTS  = 64;
  localparam int DEF_MAX_OUTPUTS = 64;
  localparam int DEF_VALUE_WIDTH = 16;

  localparam int FIELD_W     = 16;
  localparam int INDEX_W     = 6;
  localparam int COUNT_W     = 7;
  localparam int RATE_W      = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int FRAC_BITS   = 12;
  localparam int BIAS_RESET  = 410;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_INPUT_COUNT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_COUNT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEARNING_RATE = 2'd2;

  typedef enum logic [2:0] {
    OP_WR_WEIGHT = 3'd0,
    OP_WR_BIAS   = 3'd1,
    OP_LD_ACT    = 3'd2,
    OP_LD_ERR    = 3'd3,
    OP_FORWARD   = 3'd4,
    OP_BACKWARD  = 3'd5,
    OP_UPDATE    = 3'd6
  } opcode_t;

  typedef enum logic [3:0] {
    U_WR_W,
    U_WR_B,
    U_WR_A,
    U_WR_E,
    U_FWD,
    U_GRAD,
    U_PROP,
    U_ECLR,
    U_UPD
  } uop_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_FWD,
    ST_GRAD,
    ST_PROP,
    ST_ECLR,
    ST_UPD,
    ST_DRAIN
  } eng_state_t;

  typedef struct packed {
    opcode_t                    op;
    logic [INDEX_W-1:0]         row;
    logic [INDEX_W-1:0]         col;
    logic signed [FIELD_W-1:0]  data;
    logic                       prop;
  } cmd_t;

endpackage
`default_nettype wire

// ===== src/dlte_if.sv =====
// interfaces: command channel and result channel
`timescale 1ns / 1ps
`default_nettype none
interface dlte_cmd_if;
  logic                valid;
  logic                ready;
  logic [2:0]          opcode;
  logic [5:0]          row_index;
  logic [5:0]          col_index;
  logic signed [15:0]  data_value;
  logic                propagate_back;

  modport source (output valid, opcode, row_index, col_index, data_value, propagate_back,
                  input ready);
  modport sink (input valid, opcode, row_index, col_index, data_value, propagate_back,
                output ready);
endinterface

interface dlte_rsp_if;
  logic                valid;
  logic                ready;
  logic                result_kind;
  logic [5:0]          result_index;
  logic signed [15:0]  result_value;
  logic                last;

  modport source (output valid, result_kind, result_index, result_value, last,
                  input ready);
  modport sink (input valid, result_kind, result_index, result_value, last,
                output ready);
endinterface
`default_nettype wire

// ===== src/dlte_queue.sv =====
// command queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module dlte_queue
  import dlte_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      head_valid
);
  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t            slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     fill;

  assign full       = (fill == (PW+1)'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && head_valid) rd_ptr <= rd_ptr + 1'b1;
      case ({push && !full, pop && head_valid})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/dlte_front.sv =====
// front: accepts command beats and drops those with no effect
`timescale 1ns / 1ps
`default_nettype none
module dlte_front
  import dlte_pkg::*;
#(
  parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
  dlte_cmd_if.sink  req,
  input  wire logic clearing,
  input  wire logic q_full,
  output logic      push,
  output cmd_t      push_cmd
);
  logic keep;
  logic row_ok;
  logic col_ok;

  assign row_ok = ({1'b0, req.row_index} < COUNT_W'(MAX_OUTPUTS));
  assign col_ok = ({1'b0, req.col_index} < COUNT_W'(MAX_INPUTS));

  always_comb begin
    case (opcode_t'(req.opcode))
      OP_WR_WEIGHT: keep = row_ok && col_ok;
      OP_WR_BIAS:   keep = row_ok;
      OP_LD_ERR:    keep = row_ok;
      OP_LD_ACT:    keep = col_ok;
      OP_FORWARD:   keep = 1'b1;
      OP_BACKWARD:  keep = 1'b1;
      OP_UPDATE:    keep = 1'b1;
      default:      keep = 1'b0;
    endcase
  end

  assign req.ready      = !q_full && !clearing;
  assign push           = req.valid && req.ready && keep;
  assign push_cmd.op    = opcode_t'(req.opcode);
  assign push_cmd.row   = req.row_index;
  assign push_cmd.col   = req.col_index;
  assign push_cmd.data  = req.data_value;
  assign push_cmd.prop  = req.propagate_back;
endmodule
`default_nettype wire

// ===== src/dlte_back.sv =====
// back: sequencer, stores and multiply-accumulate pipeline
`timescale 1ns / 1ps
`default_nettype none
module dlte_back
  import dlte_pkg::*;
#(
  parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire cmd_t               q_head,
  output logic                    q_pop,
  output logic                    clearing,
  input  wire logic [COUNT_W-1:0] input_count,
  input  wire logic [COUNT_W-1:0] output_count,
  input  wire logic [RATE_W-1:0]  learning_rate,
  dlte_rsp_if.source              rsp
);
  localparam int VW  = VALUE_WIDTH;
  localparam int IW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int OW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int WD  = MAX_OUTPUTS * MAX_INPUTS;
  localparam int AW  = (WD > 1) ? $clog2(WD) : 1;
  localparam int PW  = 2 * VW;
  localparam int RPW = RATE_W + 1 + 32;
  localparam int RSW = RPW + 1;
  localparam int DW  = RSW + 1;
  localparam int SW  = ((PW + 1 > 32) ? PW + 1 : 32) + 1;
  localparam int DXW = (VW > FIELD_W) ? VW : FIELD_W;
  localparam int BR  = (VW >= 10) ? BIAS_RESET : (2 ** (VW - 1)) - 1;

  localparam logic signed [DXW-1:0] DX_MAX = {{(DXW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [DXW-1:0] DX_MIN = ~DX_MAX;
  localparam logic signed [DW-1:0]  D_MAX  = {{(DW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [DW-1:0]  D_MIN  = ~D_MAX;
  localparam logic signed [SW-1:0]  G_MAX  = {{(SW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SW-1:0]  G_MIN  = ~G_MAX;
  localparam logic signed [63:0]    A_MAX  = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0]    A_MIN  = ~A_MAX;
  localparam logic signed [63:0]    R_MAX  = 64'sd32767;
  localparam logic signed [63:0]    R_MIN  = -64'sd32768;

  typedef struct packed {
    logic                   valid;
    uop_t                   uop;
    logic [OW-1:0]          i;
    logic [IW-1:0]          j;
    logic                   first;
    logic                   endrow;
    logic                   final_beat;
    logic signed [VW-1:0]   data;
  } ctl_t;

  eng_state_t         state;
  eng_state_t         state_next;
  cmd_t               cur;
  logic [OW-1:0]      i;
  logic [IW-1:0]      j;
  logic [OW-1:0]      il;
  logic [IW-1:0]      jl;
  logic [AW-1:0]      clr;
  logic               adv;
  logic               pass_done;
  logic               pipe_busy;
  ctl_t               ctl0;
  ctl_t               ctl1;
  ctl_t               ctl2;
  ctl_t               ctl3;
  logic [COUNT_W-1:0] ni;
  logic [COUNT_W-1:0] no;
  logic signed [DXW-1:0] dx;
  logic signed [VW-1:0]  dsat;

  // stores
  logic signed [VW-1:0] wmem  [WD];
  logic signed [31:0]   gmem  [WD];
  logic signed [VW-1:0] amem  [MAX_INPUTS];
  logic signed [VW-1:0] emem  [MAX_OUTPUTS];
  logic signed [VW-1:0] bmem  [MAX_OUTPUTS];
  logic signed [31:0]   bgmem [MAX_OUTPUTS];

  logic [AW-1:0] ra_w;
  logic          w_we, g_we, a_we, e_we, b_we, bg_we;
  logic [AW-1:0] w_wa, g_wa;
  logic [IW-1:0] a_wa;
  logic [OW-1:0] e_wa, b_wa, bg_wa;
  logic signed [VW-1:0] w_wd, a_wd, e_wd, b_wd;
  logic signed [31:0]   g_wd, bg_wd;

  // pipeline data
  logic signed [VW-1:0]  w1, a1, e1, b1;
  logic signed [31:0]    g1, bg1;
  logic signed [VW-1:0]  ma, mb;
  logic signed [PW-1:0]  prod2;
  logic signed [RPW-1:0] rprod2, rprodb2;
  logic signed [VW-1:0]  w2, e2, b2;
  logic signed [31:0]    g2, bg2;
  logic signed [63:0]    acc3;
  logic signed [PW:0]    term3;
  logic signed [RSW-1:0] rs3, rsb3;
  logic signed [VW-1:0]  w3, e3, b3;
  logic signed [31:0]    g3, bg3;

  logic signed [64:0]    accsum;
  logic signed [63:0]    accbase;
  logic signed [63:0]    accnext;
  logic signed [PW:0]    tsum;
  logic signed [RSW-1:0] rsum, rsumb;
  logic signed [SW-1:0]  gsum;
  logic signed [32:0]    bgsum;
  logic signed [DW-1:0]  wdiff, bdiff;
  logic signed [31:0]    gnew, bgnew;
  logic signed [VW-1:0]  wnew, bnew;
  logic signed [64:0]    fsum;
  logic signed [63:0]    fsat;
  logic signed [63:0]    fq;
  logic signed [15:0]    rval;
  logic                  s4;

  // active extents
  always_comb begin
    if (input_count == '0) ni = COUNT_W'(1);
    else if (input_count > COUNT_W'(MAX_INPUTS)) ni = COUNT_W'(MAX_INPUTS);
    else ni = input_count;
    if (output_count == '0) no = COUNT_W'(1);
    else if (output_count > COUNT_W'(MAX_OUTPUTS)) no = COUNT_W'(MAX_OUTPUTS);
    else no = output_count;
  end
  assign jl = IW'(ni - COUNT_W'(1));
  assign il = OW'(no - COUNT_W'(1));

  assign adv       = !rsp.valid || rsp.ready;
  assign pipe_busy = ctl1.valid || ctl2.valid || ctl3.valid;
  assign pass_done = (i == il) && (j == jl);
  assign clearing  = (state == ST_CLEAR);

  // command data narrowed to the store width
  always_comb begin
    dx = DXW'(cur.data);
    if (dx > DX_MAX) dsat = DX_MAX[VW-1:0];
    else if (dx < DX_MIN) dsat = DX_MIN[VW-1:0];
    else dsat = dx[VW-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr == AW'(WD - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (q_valid) begin
          case (q_head.op)
            OP_FORWARD:  state_next = ST_FWD;
            OP_BACKWARD: state_next = ST_GRAD;
            OP_UPDATE:   state_next = ST_UPD;
            default:     state_next = ST_ISSUE;
          endcase
        end
      end
      ST_ISSUE: if (adv) state_next = ST_DRAIN;
      ST_FWD:   if (adv && pass_done) state_next = ST_DRAIN;
      ST_UPD:   if (adv && pass_done) state_next = ST_DRAIN;
      ST_GRAD:  if (adv && pass_done) state_next = cur.prop ? ST_PROP : ST_ECLR;
      ST_PROP:  if (adv && pass_done) state_next = ST_ECLR;
      ST_ECLR:  if (adv && (i == il)) state_next = ST_DRAIN;
      ST_DRAIN: if (!pipe_busy) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // issue stage
  always_comb begin
    q_pop           = (state == ST_IDLE) && q_valid;
    ctl0.valid      = 1'b0;
    ctl0.uop        = U_FWD;
    ctl0.i          = i;
    ctl0.j          = j;
    ctl0.first      = (j == '0);
    ctl0.endrow     = (j == jl);
    ctl0.final_beat = pass_done;
    ctl0.data       = dsat;
    case (state)
      ST_ISSUE: begin
        ctl0.valid = 1'b1;
        ctl0.i     = cur.row[OW-1:0];
        ctl0.j     = cur.col[IW-1:0];
        case (cur.op)
          OP_WR_WEIGHT: ctl0.uop = U_WR_W;
          OP_WR_BIAS:   ctl0.uop = U_WR_B;
          OP_LD_ACT:    ctl0.uop = U_WR_A;
          default:      ctl0.uop = U_WR_E;
        endcase
      end
      ST_FWD: begin
        ctl0.valid = 1'b1;
        ctl0.uop   = U_FWD;
      end
      ST_GRAD: begin
        ctl0.valid = 1'b1;
        ctl0.uop   = U_GRAD;
      end
      ST_UPD: begin
        ctl0.valid = 1'b1;
        ctl0.uop   = U_UPD;
      end
      ST_PROP: begin
        ctl0.valid  = 1'b1;
        ctl0.uop    = U_PROP;
        ctl0.first  = (i == '0);
        ctl0.endrow = (i == il);
      end
      ST_ECLR: begin
        ctl0.valid = 1'b1;
        ctl0.uop   = U_ECLR;
      end
      default: ctl0.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
      i     <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr <= clr + 1'b1;
      if (q_pop) begin
        i <= '0;
        j <= '0;
      end else if (adv) begin
        case (state)
          ST_FWD, ST_GRAD, ST_UPD: begin
            if (pass_done) begin
              i <= '0;
              j <= '0;
            end else if (j == jl) begin
              j <= '0;
              i <= i + 1'b1;
            end else begin
              j <= j + 1'b1;
            end
          end
          ST_PROP: begin
            if (pass_done) begin
              i <= '0;
              j <= '0;
            end else if (i == il) begin
              i <= '0;
              j <= j + 1'b1;
            end else begin
              i <= i + 1'b1;
            end
          end
          ST_ECLR: i <= (i == il) ? '0 : i + 1'b1;
          default: i <= i;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
  end

  // store write ports
  assign s4   = adv && ctl3.valid;
  assign ra_w = AW'(int'(ctl0.i) * MAX_INPUTS + int'(ctl0.j));

  always_comb begin
    w_wa  = AW'(int'(ctl3.i) * MAX_INPUTS + int'(ctl3.j));
    w_we  = s4 && ((ctl3.uop == U_WR_W) || (ctl3.uop == U_UPD));
    w_wd  = (ctl3.uop == U_WR_W) ? ctl3.data : wnew;
    a_we  = s4 && (ctl3.uop == U_WR_A);
    a_wa  = ctl3.j;
    a_wd  = ctl3.data;
    if (clearing) begin
      g_we  = 1'b1;
      g_wa  = clr;
      g_wd  = '0;
      e_we  = (clr < AW'(MAX_OUTPUTS));
      e_wa  = clr[OW-1:0];
      e_wd  = '0;
      b_we  = e_we;
      b_wa  = clr[OW-1:0];
      b_wd  = VW'(BR);
      bg_we = e_we;
      bg_wa = clr[OW-1:0];
      bg_wd = '0;
    end else begin
      g_we  = s4 && ((ctl3.uop == U_GRAD) || (ctl3.uop == U_UPD));
      g_wa  = w_wa;
      g_wd  = (ctl3.uop == U_GRAD) ? gnew : '0;
      e_we  = s4 && ((ctl3.uop == U_WR_E) || (ctl3.uop == U_ECLR));
      e_wa  = ctl3.i;
      e_wd  = (ctl3.uop == U_WR_E) ? ctl3.data : '0;
      b_we  = s4 && ((ctl3.uop == U_WR_B) || ((ctl3.uop == U_UPD) && ctl3.first));
      b_wa  = ctl3.i;
      b_wd  = (ctl3.uop == U_WR_B) ? ctl3.data : bnew;
      bg_we = s4 && ctl3.first && ((ctl3.uop == U_GRAD) || (ctl3.uop == U_UPD));
      bg_wa = ctl3.i;
      bg_wd = (ctl3.uop == U_GRAD) ? bgnew : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_wa] <= w_wd;
    if (adv) w1 <= wmem[ra_w];
  end
  always_ff @(posedge clk) begin
    if (g_we) gmem[g_wa] <= g_wd;
    if (adv) g1 <= gmem[ra_w];
  end
  always_ff @(posedge clk) begin
    if (a_we) amem[a_wa] <= a_wd;
    if (adv) a1 <= amem[ctl0.j];
  end
  always_ff @(posedge clk) begin
    if (e_we) emem[e_wa] <= e_wd;
    if (adv) e1 <= emem[ctl0.i];
  end
  always_ff @(posedge clk) begin
    if (b_we) bmem[b_wa] <= b_wd;
    if (adv) b1 <= bmem[ctl0.i];
  end
  always_ff @(posedge clk) begin
    if (bg_we) bgmem[bg_wa] <= bg_wd;
    if (adv) bg1 <= bgmem[ctl0.i];
  end

  // multiply stage
  always_comb begin
    case (ctl1.uop)
      U_FWD:   begin ma = w1; mb = a1; end
      U_GRAD:  begin ma = e1; mb = a1; end
      default: begin ma = e1; mb = w1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod2   <= ma * mb;
      rprod2  <= $signed({1'b0, learning_rate}) * g1;
      rprodb2 <= $signed({1'b0, learning_rate}) * bg1;
      w2      <= w1;
      e2      <= e1;
      b2      <= b1;
      g2      <= g1;
      bg2     <= bg1;
    end
  end

  // accumulate and round stage
  always_comb begin
    if (!ctl2.first) accbase = acc3;
    else if (ctl2.uop == U_FWD) accbase = 64'(b2) <<< FRAC_BITS;
    else accbase = '0;
    accsum = 65'(accbase) + 65'(prod2);
    if (accsum[64] != accsum[63]) accnext = accsum[64] ? A_MIN : A_MAX;
    else accnext = accsum[63:0];
    tsum  = (PW+1)'(prod2) + (PW+1)'(2 ** (FRAC_BITS - 1));
    rsum  = RSW'(rprod2) + RSW'(2 ** 15);
    rsumb = RSW'(rprodb2) + RSW'(2 ** 15);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc3  <= accnext;
      term3 <= tsum >>> FRAC_BITS;
      rs3   <= rsum >>> 16;
      rsb3  <= rsumb >>> 16;
      w3    <= w2;
      e3    <= e2;
      b3    <= b2;
      g3    <= g2;
      bg3   <= bg2;
    end
  end

  // write-back and result stage
  always_comb begin
    gsum = SW'(g3) + SW'(term3);
    if (gsum > G_MAX) gnew = 32'sh7fffffff;
    else if (gsum < G_MIN) gnew = -32'sh80000000;
    else gnew = gsum[31:0];
    bgsum = 33'(bg3) + 33'(e3);
    if (bgsum[32] != bgsum[31]) bgnew = bgsum[32] ? -32'sh80000000 : 32'sh7fffffff;
    else bgnew = bgsum[31:0];
    wdiff = DW'(w3) - DW'(rs3);
    if (wdiff > D_MAX) wnew = D_MAX[VW-1:0];
    else if (wdiff < D_MIN) wnew = D_MIN[VW-1:0];
    else wnew = wdiff[VW-1:0];
    bdiff = DW'(b3) - DW'(rsb3);
    if (bdiff > D_MAX) bnew = D_MAX[VW-1:0];
    else if (bdiff < D_MIN) bnew = D_MIN[VW-1:0];
    else bnew = bdiff[VW-1:0];
    fsum = 65'(acc3) + 65'(2 ** (FRAC_BITS - 1));
    if (fsum[64] != fsum[63]) fsat = fsum[64] ? A_MIN : A_MAX;
    else fsat = fsum[63:0];
    fq = fsat >>> FRAC_BITS;
    if (fq > R_MAX) rval = 16'sh7fff;
    else if (fq < R_MIN) rval = -16'sh8000;
    else rval = fq[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
      ctl2.valid <= 1'b0;
      ctl3.valid <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      if (adv) begin
        ctl1.valid <= ctl0.valid;
        ctl2.valid <= ctl1.valid;
        ctl3.valid <= ctl2.valid;
      end
      if (s4 && ctl3.endrow && ((ctl3.uop == U_FWD) || (ctl3.uop == U_PROP))) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      {ctl1.uop, ctl1.i, ctl1.j, ctl1.first, ctl1.endrow, ctl1.final_beat, ctl1.data} <=
        {ctl0.uop, ctl0.i, ctl0.j, ctl0.first, ctl0.endrow, ctl0.final_beat, ctl0.data};
      {ctl2.uop, ctl2.i, ctl2.j, ctl2.first, ctl2.endrow, ctl2.final_beat, ctl2.data} <=
        {ctl1.uop, ctl1.i, ctl1.j, ctl1.first, ctl1.endrow, ctl1.final_beat, ctl1.data};
      {ctl3.uop, ctl3.i, ctl3.j, ctl3.first, ctl3.endrow, ctl3.final_beat, ctl3.data} <=
        {ctl2.uop, ctl2.i, ctl2.j, ctl2.first, ctl2.endrow, ctl2.final_beat, ctl2.data};
    end
    if (s4 && ctl3.endrow && ((ctl3.uop == U_FWD) || (ctl3.uop == U_PROP))) begin
      rsp.result_kind  <= (ctl3.uop == U_PROP);
      rsp.result_index <= (ctl3.uop == U_PROP) ? INDEX_W'(ctl3.j) : INDEX_W'(ctl3.i);
      rsp.result_value <= rval;
      rsp.last         <= ctl3.final_beat;
    end
  end
endmodule
`default_nettype wire

// ===== src/dense_layer_train_engine.sv =====
// top level: dense layer with forward, backward and gradient update passes
//
//   channel  dir  handshake            payload
//   req      in   valid / ready        opcode, row_index, col_index, data_value, propagate_back
//   rsp      out  valid / ready        result_kind, result_index, result_value, last
//   cfg      in   cfg_we               cfg_index, cfg_data
//
// after reset a clearing pass over every weight address zeroes the gradient
// store and resets biases and errors; commands are held off, config writes are taken
// store writes issue one beat; forward, update and backward pass once over outputs * inputs,
// backward again when propagate_back is set and then clears errors; one weight memory access
// per cycle unless stalled; a stalled result freezes the pipeline, the queue keeps filling
`timescale 1ns / 1ps
`default_nettype none
module dense_layer_train_engine
  import dlte_pkg::*;
#(
  parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  dlte_cmd_if.sink                    req,
  dlte_rsp_if.source                  rsp,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);
  logic [COUNT_W-1:0] input_count;
  logic [COUNT_W-1:0] output_count;
  logic [RATE_W-1:0]  learning_rate;
  logic               push;
  cmd_t               push_cmd;
  logic               q_full;
  logic               q_pop;
  cmd_t               q_head;
  logic               q_valid;
  logic               clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_count   <= COUNT_W'(64);
      output_count  <= COUNT_W'(64);
      learning_rate <= RATE_W'(6554);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INPUT_COUNT:   input_count   <= cfg_data[COUNT_W-1:0];
        CFG_OUTPUT_COUNT:  output_count  <= cfg_data[COUNT_W-1:0];
        CFG_LEARNING_RATE: learning_rate <= cfg_data[RATE_W-1:0];
        default:           input_count   <= input_count;
      endcase
    end
  end

  dlte_front #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_front (
    .req      (req),
    .clearing (clearing),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  dlte_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_valid)
  );

  dlte_back #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .input_count   (input_count),
    .output_count  (output_count),
    .learning_rate (learning_rate),
    .rsp           (rsp)
  );
endmodule
`default_nettype wire

// ===== src/dlte_checker.sv =====
// checker: port-level properties of the engine, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module dlte_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_kind,
  input wire logic [5:0]  out_index,
  input wire logic [15:0] out_value,
  input wire logic        out_last
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({out_kind, out_index, out_value, out_last}))
    else $error("result payload changed while stalled");

  a_clear_blocks: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("commands taken during clearing pass");

  a_no_early_result: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");
endmodule

bind dense_layer_train_engine dlte_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_kind  (rsp.result_kind),
  .out_index (rsp.result_index),
  .out_value (rsp.result_value),
  .out_last  (rsp.last)
);
`default_nettype wire
